// ===== hw/rtl/uhfd_pkg.sv =====
`default_nettype none

package uhfd_pkg;

	// Frame length arithmetic: 7 overhead bytes plus a 16-bit payload length
	localparam int LEN_W          = 17;
	localparam int FRAME_OVERHEAD = 7;

	localparam int BUFFER_BYTES_DEF = 256;

	localparam logic [7:0] HEADER_RST = 8'hBB;
	localparam logic [7:0] END_RST    = 8'h7E;

	// Configuration register indexes
	typedef enum logic {
		REG_HEADER = 1'b0,
		REG_END    = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_MORE     = 3'd0,
		ST_GOOD     = 3'd1,
		ST_BAD_SUM  = 3'd2,
		ST_BAD_END  = 3'd3,
		ST_TOO_LONG = 3'd4
	} frame_status_t;

	// One result beat as produced by the frame tracker
	typedef struct packed {
		logic          emit;
		logic [7:0]    data;
		logic [7:0]    index;
		logic          last;
		frame_status_t status;
	} trk_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uhfd_tracker.sv =====
`default_nettype none

module uhfd_tracker #(
	parameter int BUFFER_BYTES = uhfd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [7:0]          header_byte,
	input  wire logic [7:0]          end_byte,
	output uhfd_pkg::trk_result_t    res
);
	import uhfd_pkg::*;

	localparam int PW = $clog2(BUFFER_BYTES + 1);

	logic [PW-1:0]    pos_q;
	logic [7:0]       sum_q;
	logic [7:0]       len_hi_q;
	logic [LEN_W-1:0] exp_q;

	logic [PW-1:0]    pos_nxt;
	logic [7:0]       sum_nxt;
	logic [7:0]       len_hi_nxt;
	logic [LEN_W-1:0] exp_nxt;

	logic [LEN_W-1:0] pos_ext;
	logic [LEN_W-1:0] sum_end;
	logic             hunting;
	logic             abort;
	logic             done;

	assign pos_ext = LEN_W'(pos_q);
	assign sum_end = exp_q - LEN_W'(3);
	assign hunting = (pos_q == '0);
	assign abort   = (pos_q == PW'(BUFFER_BYTES));

	always_comb begin
		pos_nxt    = pos_q + PW'(1);
		sum_nxt    = sum_q;
		len_hi_nxt = len_hi_q;
		exp_nxt    = exp_q;
		done       = 1'b0;

		res.emit   = !(hunting && rx_byte != header_byte);
		res.data   = rx_byte;
		res.index  = 8'(pos_q);
		res.last   = 1'b0;
		res.status = ST_MORE;

		if (pos_q == PW'(3)) begin
			len_hi_nxt = rx_byte;
		end
		if (pos_q == PW'(4)) begin
			exp_nxt = LEN_W'(FRAME_OVERHEAD) + LEN_W'({len_hi_q, rx_byte});
		end

		if (pos_q >= PW'(1) && pos_q <= PW'(4)) begin
			sum_nxt = sum_q + rx_byte;
		end else if (pos_q > PW'(4)) begin
			if (pos_ext <= sum_end) begin
				sum_nxt = sum_q + rx_byte;
			end else if (pos_ext == sum_end + LEN_W'(1)) begin
				sum_nxt = sum_q - rx_byte;
			end
		end

		if (abort) begin
			done       = 1'b1;
			res.last   = 1'b1;
			res.status = ST_TOO_LONG;
		end else if (exp_nxt != '0 && pos_ext + LEN_W'(1) == exp_nxt) begin
			done     = 1'b1;
			res.last = 1'b1;
			if (rx_byte != end_byte) begin
				res.status = ST_BAD_END;
			end else if (sum_nxt != 8'd0) begin
				res.status = ST_BAD_SUM;
			end else begin
				res.status = ST_GOOD;
			end
		end

		if (done) begin
			pos_nxt    = '0;
			sum_nxt    = 8'd0;
			len_hi_nxt = 8'd0;
			exp_nxt    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= 8'd0;
			len_hi_q <= 8'd0;
			exp_q    <= '0;
		end else if (step && res.emit) begin
			pos_q    <= pos_nxt;
			sum_q    <= sum_nxt;
			len_hi_q <= len_hi_nxt;
			exp_q    <= exp_nxt;
		end
	end

	a_return_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit && res.last) |=> (pos_q == '0))
		else $error("tracker did not return to hunting after frame end");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(BUFFER_BYTES))
		else $error("frame position ran past buffer size");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |-> (res.last == (res.status != ST_MORE)))
		else $error("last flag and frame status disagree");

	a_no_len_while_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		hunting |-> (exp_q == '0 && sum_q == 8'd0))
		else $error("stale frame state while hunting");

endmodule

`default_nettype wire

// ===== hw/rtl/uhf_reader_frame_deframer.sv =====
// Length-prefixed frame deframer with an 8-bit additive checksum. Bytes arrive
// one per beat on the in channel. While hunting, every byte other than the
// header byte is dropped with no output beat. Once a header is seen each byte,
// header included, leaves on the out channel with its position (low 8 bits).
// Bytes 3 and 4 carry a big-endian payload length L; the frame is 7 + L bytes.
// The byte at length-2 is the checksum (low 8 bits of the sum of bytes 1 to
// length-3) and the final byte must equal the end byte. The final beat has
// last set and a status of good, bad checksum or bad end byte (bad end byte
// wins when both are wrong). A frame still running at position BUFFER_BYTES
// is cut there with last set and status too long. Throughput is one byte per
// clock. Bytes pass the input register, then the result register fed by the
// frame tracker's update of counter, sum and length. A byte waits in the
// input register only while the result register is full and stalled. The
// user must write header and end byte values on the config port while the
// block is idle; the block does not enforce it. Reset values: 0xBB, 0x7E.

`default_nettype none

module uhf_reader_frame_deframer #(
	parameter int BUFFER_BYTES = uhfd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	// config port
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,

	// in channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,

	// out channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic [7:0]      byte_index,
	output logic            last,
	output logic [2:0]      frame_status
);
	import uhfd_pkg::*;

	logic [7:0]  header_byte_q;
	logic [7:0]  end_byte_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        out_valid_q;
	trk_result_t out_q;

	trk_result_t res;
	logic        slot_free;
	logic        advance;
	logic        in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_RST;
			end_byte_q    <= END_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_HEADER: header_byte_q <= cfg_data;
				REG_END:    end_byte_q    <= cfg_data;
				default:    header_byte_q <= header_byte_q;
			endcase
		end
	end

	// Output slot is free when empty or being drained this cycle. A dropped
	// hunt byte needs no slot, so it never waits.
	assign slot_free = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!res.emit || slot_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	uhfd_tracker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.header_byte (header_byte_q),
		.end_byte    (end_byte_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = out_q.data;
	assign byte_index   = out_q.index;
	assign last         = out_q.last;
	assign frame_status = out_q.status;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("held result beat was overwritten");

	a_emit_only_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !valid_s1) |=> !out_valid_q)
		else $error("result beat appeared with no byte in flight");

endmodule

`default_nettype wire
